// ----- src/p422_pkg.sv -----
// Shared types, constants and the clamp function for the packed 4:2:2 to RGB block.
// Used by p422_lane, p422_merge and packed_422_to_rgba_top; depends on nothing else.
package p422_pkg;

   // Layout codes held in the format register.
   typedef enum logic [1:0] {
      LAYOUT_UYVY = 2'd0,
      LAYOUT_YUY2 = 2'd1,
      LAYOUT_GRGB = 2'd2,
      LAYOUT_RGBG = 2'd3
   } layout_type;

   // One RGB pixel.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // Shared chroma pair, both centered at zero.
   typedef struct packed {
      logic signed [8:0] cb;
      logic signed [8:0] cr;
   } chroma_type;

   // BT.601 video-range coefficients in 8.8 fixed point.
   localparam int LUMA_OFFSET  = 16;
   localparam int LUMA_GAIN    = 298;
   localparam int ROUND_BIAS   = 128;
   localparam int CHROMA_BIAS  = 128;
   localparam int CR_TO_RED    = 409;
   localparam int CB_TO_GREEN  = -100;
   localparam int CR_TO_GREEN  = -208;
   localparam int CB_TO_BLUE   = 516;

   // Widths of the registered partial terms and of the final sum.
   localparam int LUMA_W  = 18;
   localparam int RED_W   = 17;
   localparam int GREEN_W = 17;
   localparam int BLUE_W  = 18;
   localparam int SUM_W   = 20;
   localparam int FRAC_W  = 8;

   // Floor-shift a fixed-point sum and saturate it to 0..255.
   function automatic logic [7:0] clamp_shift(input logic signed [SUM_W-1:0] sum);
      logic signed [SUM_W-FRAC_W-1:0] whole;
      logic [7:0]                     result;
      whole = (SUM_W-FRAC_W)'(sum >>> FRAC_W);
      if (whole < 0) begin
         result = 8'd0;
      end else if (whole > 255) begin
         result = 8'd255;
      end else begin
         result = whole[7:0];
      end
      return result;
   endfunction

endpackage

// ----- src/packed_422_to_rgba_top.sv -----
// Packed 4:2:2 block to two RGB pixels, BT.601 video range or byte swizzle.
// A request accepted into the lane product registers is then captured in the merge output registers and is
// on the result ports, strobed by rsp_valid, for one cycle; it is taken in that cycle.
// Throughput: one request per cycle; busy is never raised, since the multiply and sum/clamp
// stages of both pixel lanes advance every cycle. Reset is synchronous and active high: it
// clears the pipeline strobes and sets the layout to UYVY. The receiver cannot stall.
module packed_422_to_rgba_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_start,
   output logic       busy,
   input  logic [7:0] req_byte_zero,
   input  logic [7:0] req_byte_one,
   input  logic [7:0] req_byte_two,
   input  logic [7:0] req_byte_three,
   output logic       rsp_valid,
   output logic [7:0] rsp_red_first,
   output logic [7:0] rsp_green_first,
   output logic [7:0] rsp_blue_first,
   output logic [7:0] rsp_red_second,
   output logic [7:0] rsp_green_second,
   output logic [7:0] rsp_blue_second,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_layout_mode
);
   import p422_pkg::*;

   layout_type layout_in, layout_ff;
   logic       accept;
   logic       stage_valid_ff;
   logic       rsp_valid_ff;
   logic [7:0] luma_first, luma_second;
   chroma_type chroma;
   pixel_type  lane_first, lane_second;
   pixel_type  pixel_first, pixel_second;

   // The pipeline never stalls, so requests and register writes are always taken.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = req_start && !busy;

   // Format register.
   assign layout_in = (csr_valid && csr_ready) ? layout_type'(csr_layout_mode) : layout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= LAYOUT_UYVY;
      end else begin
         layout_ff <= layout_in;
      end
   end

   // Unpack luma and chroma bytes according to the layout.
   always_comb begin
      case (layout_ff)
         LAYOUT_UYVY: begin
            chroma.cb   = $signed({1'b0, req_byte_zero}) - 9'(CHROMA_BIAS);
            luma_first  = req_byte_one;
            chroma.cr   = $signed({1'b0, req_byte_two}) - 9'(CHROMA_BIAS);
            luma_second = req_byte_three;
         end
         default: begin
            luma_first  = req_byte_zero;
            chroma.cb   = $signed({1'b0, req_byte_one}) - 9'(CHROMA_BIAS);
            luma_second = req_byte_two;
            chroma.cr   = $signed({1'b0, req_byte_three}) - 9'(CHROMA_BIAS);
         end
      endcase
   end

   // Two pixel lanes share the chroma pair.
   p422_lane u_lane_first (
      .clock  (clock),
      .load   (accept),
      .luma   (luma_first),
      .chroma (chroma),
      .pixel  (lane_first)
   );

   p422_lane u_lane_second (
      .clock  (clock),
      .load   (accept),
      .luma   (luma_second),
      .chroma (chroma),
      .pixel  (lane_second)
   );

   p422_merge u_merge (
      .clock        (clock),
      .load         (accept),
      .hold         (stage_valid_ff),
      .layout       (layout_ff),
      .byte_zero    (req_byte_zero),
      .byte_one     (req_byte_one),
      .byte_two     (req_byte_two),
      .byte_three   (req_byte_three),
      .lane_first   (lane_first),
      .lane_second  (lane_second),
      .pixel_first  (pixel_first),
      .pixel_second (pixel_second)
   );

   // Strobe pipeline that follows each request through both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= accept;
         rsp_valid_ff   <= stage_valid_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red_first    = pixel_first.red;
   assign rsp_green_first  = pixel_first.green;
   assign rsp_blue_first   = pixel_first.blue;
   assign rsp_red_second   = pixel_second.red;
   assign rsp_green_second = pixel_second.green;
   assign rsp_blue_second  = pixel_second.blue;

   // Every result traces back to a request that passed through both strobe registers.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> $past(accept, 2))
      else $error("result strobe without a matching request");

   // Every request produces a result after passing through both strobe registers.
   assert property (@(posedge clock) disable iff (reset) accept |=> ##1 rsp_valid)
      else $error("request lost in the pipeline");

   // In swizzle layouts both pixels carry the same red and blue bytes.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(layout_ff, 2) == LAYOUT_GRGB || $past(layout_ff, 2) == LAYOUT_RGBG))
      |-> (rsp_red_first == rsp_red_second && rsp_blue_first == rsp_blue_second))
      else $error("swizzle result does not share red and blue");

endmodule

// ----- src/p422_lane.sv -----
// One pixel lane: registers the luma and chroma products, then sums, shifts and clamps.
// Depends on p422_pkg.
module p422_lane (
   input  logic                  clock,
   input  logic                  load,
   input  logic [7:0]            luma,
   input  p422_pkg::chroma_type  chroma,
   output p422_pkg::pixel_type   pixel
);
   import p422_pkg::*;

   logic signed [8:0]         luma_diff;
   logic signed [LUMA_W-1:0]  luma_term_in,  luma_term_ff;
   logic signed [RED_W-1:0]   red_term_in,   red_term_ff;
   logic signed [GREEN_W-1:0] green_term_in, green_term_ff;
   logic signed [BLUE_W-1:0]  blue_term_in,  blue_term_ff;
   logic signed [SUM_W-1:0]   red_sum, green_sum, blue_sum;

   // Product stage: one constant multiply per term, two for the green term.
   always_comb begin
      luma_diff     = $signed({1'b0, luma}) - 9'(LUMA_OFFSET);
      luma_term_in  = LUMA_W'(luma_diff * LUMA_GAIN + ROUND_BIAS);
      red_term_in   = RED_W'(chroma.cr * CR_TO_RED);
      green_term_in = GREEN_W'(chroma.cb * CB_TO_GREEN + chroma.cr * CR_TO_GREEN);
      blue_term_in  = BLUE_W'(chroma.cb * CB_TO_BLUE);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         luma_term_ff  <= luma_term_in;
         red_term_ff   <= red_term_in;
         green_term_ff <= green_term_in;
         blue_term_ff  <= blue_term_in;
      end
   end

   // Sum stage: add the luma term to each chroma term and saturate.
   always_comb begin
      red_sum     = SUM_W'(luma_term_ff) + SUM_W'(red_term_ff);
      green_sum   = SUM_W'(luma_term_ff) + SUM_W'(green_term_ff);
      blue_sum    = SUM_W'(luma_term_ff) + SUM_W'(blue_term_ff);
      pixel.red   = clamp_shift(red_sum);
      pixel.green = clamp_shift(green_sum);
      pixel.blue  = clamp_shift(blue_sum);
   end

endmodule

// ----- src/p422_merge.sv -----
// Merge stage: picks lane results or the byte swizzle per layout and registers the outputs.
// Depends on p422_pkg.
module p422_merge (
   input  logic                 clock,
   input  logic                 load,
   input  logic                 hold,
   input  p422_pkg::layout_type layout,
   input  logic [7:0]           byte_zero,
   input  logic [7:0]           byte_one,
   input  logic [7:0]           byte_two,
   input  logic [7:0]           byte_three,
   input  p422_pkg::pixel_type  lane_first,
   input  p422_pkg::pixel_type  lane_second,
   output p422_pkg::pixel_type  pixel_first,
   output p422_pkg::pixel_type  pixel_second
);
   import p422_pkg::*;

   layout_type layout_ff;
   logic [7:0] byte_zero_ff, byte_one_ff, byte_two_ff, byte_three_ff;
   pixel_type  first_in,  first_ff;
   pixel_type  second_in, second_ff;

   // Capture the layout and raw bytes alongside the lane product stage.
   always_ff @(posedge clock) begin
      if (load) begin
         layout_ff     <= layout;
         byte_zero_ff  <= byte_zero;
         byte_one_ff   <= byte_one;
         byte_two_ff   <= byte_two;
         byte_three_ff <= byte_three;
      end
   end

   // Select converted pixels or rearranged bytes; red and blue are shared in swizzle modes.
   always_comb begin
      case (layout_ff)
         LAYOUT_UYVY, LAYOUT_YUY2: begin
            first_in  = lane_first;
            second_in = lane_second;
         end
         LAYOUT_GRGB: begin
            first_in  = '{red: byte_one_ff, green: byte_zero_ff, blue: byte_three_ff};
            second_in = '{red: byte_one_ff, green: byte_two_ff,  blue: byte_three_ff};
         end
         LAYOUT_RGBG: begin
            first_in  = '{red: byte_zero_ff, green: byte_one_ff,   blue: byte_two_ff};
            second_in = '{red: byte_zero_ff, green: byte_three_ff, blue: byte_two_ff};
         end
         default: begin
            first_in  = lane_first;
            second_in = lane_second;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (hold) begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   assign pixel_first  = first_ff;
   assign pixel_second = second_ff;

endmodule
